@@ src/linked_list_queue_manager_top_assert.svh @@
// Assertion macros for the linked list queue manager.
// Included by the top level; no other dependencies.
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LLQM_ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("llqm same-cycle check failed");
// next-cycle implication
`define LLQM_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("llqm next-cycle check failed");
`else
`define LLQM_ASSERT_IMPLY(lbl, a, c)
`define LLQM_ASSERT_NEXT(lbl, a, c)
`endif

`endif

@@ src/llqm_pkg.sv @@
// Shared constants, codes and types of the linked list queue manager.
// No dependencies.
package llqm_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int NUM_LISTS   = 16;
    localparam int DATA_W      = 32;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int DIN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int DOUT_W   = 32;
    localparam int COUNT_W  = 10;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = SLOT_W;
    localparam int STEP_W = $clog2(TABLE_SLOTS + 1);
    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    localparam logic [FUNC_W-1:0] FN_OPEN       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_OPEN  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OPEN_TAKE,
        S_PUSH_TAKE,
        S_PUSH_TAIL,
        S_POP_ONE,
        S_POP_FRONT,
        S_WALK,
        S_PB_CUT,
        S_PB_FREE,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN,
        OP_RELEASE,
        OP_PUSH_HELD,
        OP_OPEN,
        OP_PUSH_TAKE,
        OP_PUSH_TAIL,
        OP_POP_ONE,
        OP_POP_FRONT,
        OP_WALK,
        OP_PB_CUT,
        OP_PB_FREE,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic                in_ready;
        t_dp_op              op;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic              in_valid;
        logic              out_free;
        logic              id_ok;
        logic              is_open;
        logic              cnt_zero;
        logic              cnt_one;
        logic              free_empty;
        logic              walk_more;
        logic              clear_last;
        logic [FUNC_W-1:0] func;
    } t_stat;

endpackage

@@ src/llqm_if.sv @@
// Request and response channel interfaces (valid/ready with payload).
// Depends on llqm_pkg.
interface llqm_req_if import llqm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   list_id;
    logic [DIN_W-1:0]  data_in;

    modport source (output valid, output func, output list_id, output data_in, input ready);
    modport sink (input valid, input func, input list_id, input data_in, output ready);
endinterface

interface llqm_rsp_if import llqm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DOUT_W-1:0]   data_out;
    logic [COUNT_W-1:0]  count_out;

    modport source (output valid, output status, output data_out, output count_out,
                    input ready);
    modport sink (input valid, input status, input data_out, input count_out,
                  output ready);
endinterface

@@ src/llqm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/llqm_ctrl.sv @@
// Operation sequencer of the queue manager: one item at a time.
// Depends on llqm_pkg; drives the datapath through t_cmd, reads t_stat.
module llqm_ctrl import llqm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    logic w_is_push;
    logic w_is_pop;

    assign w_is_push = (i_stat.func == FN_PUSH_FRONT) || (i_stat.func == FN_PUSH_BACK);
    assign w_is_pop  = (i_stat.func == FN_POP_FRONT) || (i_stat.func == FN_POP_BACK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_stat.in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (i_stat.id_ok && i_stat.func <= FN_POP_BACK) begin
                    if (i_stat.func == FN_OPEN) begin
                        if (!i_stat.is_open && !i_stat.free_empty) n_state = S_OPEN_TAKE;
                    end else if (i_stat.is_open) begin
                        if (w_is_push && !i_stat.cnt_zero && !i_stat.free_empty) begin
                            n_state = S_PUSH_TAKE;
                        end else if (w_is_pop && !i_stat.cnt_zero) begin
                            if (i_stat.cnt_one) begin
                                n_state = S_POP_ONE;
                            end else if (i_stat.func == FN_POP_FRONT) begin
                                n_state = S_POP_FRONT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    end
                end
            end
            S_PUSH_TAKE: begin
                n_state = (i_stat.func == FN_PUSH_BACK) ? S_PUSH_TAIL : S_OUT;
            end
            S_WALK: begin
                if (!i_stat.walk_more) n_state = S_PB_CUT;
            end
            S_PB_CUT:    n_state = S_PB_FREE;
            S_OPEN_TAKE,
            S_PUSH_TAIL,
            S_POP_ONE,
            S_POP_FRONT,
            S_PB_FREE:   n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = OP_NOP;
        o_cmd.status   = STS_OK;
        case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) o_cmd.op = OP_LOAD;
            end
            S_DECODE: begin
                o_cmd.op = OP_SCAN;
                if (!i_stat.id_ok) begin
                    if (i_stat.func <= FN_POP_BACK) o_cmd.status = STS_NOT_OPEN;
                end else if (i_stat.func > FN_POP_BACK) begin
                    o_cmd.status = STS_OK;
                end else if (i_stat.func == FN_OPEN) begin
                    if (!i_stat.is_open && i_stat.free_empty) o_cmd.status = STS_EXHAUSTED;
                end else if (!i_stat.is_open) begin
                    o_cmd.status = STS_NOT_OPEN;
                end else if (i_stat.func == FN_RELEASE) begin
                    o_cmd.op = OP_RELEASE;
                end else if (w_is_push) begin
                    if (i_stat.cnt_zero) begin
                        o_cmd.op = OP_PUSH_HELD;
                    end else if (i_stat.free_empty) begin
                        o_cmd.status = STS_EXHAUSTED;
                    end
                end else if (i_stat.cnt_zero) begin
                    o_cmd.status = STS_EMPTY;
                end
            end
            S_OPEN_TAKE: o_cmd.op = OP_OPEN;
            S_PUSH_TAKE: o_cmd.op = OP_PUSH_TAKE;
            S_PUSH_TAIL: o_cmd.op = OP_PUSH_TAIL;
            S_POP_ONE:   o_cmd.op = OP_POP_ONE;
            S_POP_FRONT: o_cmd.op = OP_POP_FRONT;
            S_WALK:      o_cmd.op = OP_WALK;
            S_PB_CUT:    o_cmd.op = OP_PB_CUT;
            S_PB_FREE:   o_cmd.op = OP_PB_FREE;
            S_OUT: begin
                if (i_stat.out_free) o_cmd.op = OP_EMIT;
            end
            default:     o_cmd.op = OP_NOP;
        endcase
    end
endmodule

@@ src/llqm_dp.sv @@
// Datapath of the queue manager: list descriptors, free head, link and slot
// RAMs, result and output registers. Depends on llqm_pkg, llqm_if, llqm_ram.
module llqm_dp import llqm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    llqm_req_if.sink     i_req,
    llqm_rsp_if.source   o_rsp
);
    // control state
    logic [SLOT_W-1:0]    r_clr;
    logic [SLOT_W-1:0]    r_free_head;
    logic [NUM_LISTS-1:0] r_open;
    logic [CNT_W-1:0]     r_count [NUM_LISTS];
    logic                 r_out_valid;

    // payload
    logic [FUNC_W-1:0]   r_func;
    logic [ID_W-1:0]     r_id;
    logic [DIN_W-1:0]    r_din;
    logic [SLOT_W-1:0]   r_head [NUM_LISTS];
    logic [SLOT_W-1:0]   r_tail [NUM_LISTS];
    logic [SLOT_W-1:0]   r_node;
    logic [SLOT_W-1:0]   r_p;
    logic [STEP_W-1:0]   r_steps;
    logic [STATUS_W-1:0] r_res_status;
    logic [DOUT_W-1:0]   r_res_dout;
    logic [CNT_W-1:0]    r_res_cnt;
    logic [STATUS_W-1:0] r_out_status;
    logic [DOUT_W-1:0]   r_out_dout;
    logic [COUNT_W-1:0]  r_out_cnt;

    logic              w_id_ok;
    logic [LIST_W-1:0] w_li;
    logic [SLOT_W-1:0] w_h;
    logic [SLOT_W-1:0] w_t;
    logic [CNT_W-1:0]  w_c;
    logic              w_open;
    logic              w_walk_more;
    logic              w_clear_last;
    logic              w_front;

    logic              w_lk_we;
    logic [SLOT_W-1:0] w_lk_waddr;
    logic [SLOT_W-1:0] w_lk_wdata;
    logic              w_lk_re;
    logic [SLOT_W-1:0] w_lk_raddr;
    logic [SLOT_W-1:0] w_lk_rdata;
    logic              w_sl_we;
    logic [SLOT_W-1:0] w_sl_waddr;
    logic              w_sl_re;
    logic [SLOT_W-1:0] w_sl_raddr;
    logic [DATA_W-1:0] w_sl_rdata;

    assign w_id_ok      = 32'(r_id) < 32'(NUM_LISTS);
    assign w_li         = LIST_W'(r_id);
    assign w_h          = r_head[w_li];
    assign w_t          = r_tail[w_li];
    assign w_c          = r_count[w_li];
    assign w_open       = w_id_ok && r_open[w_li];
    assign w_front      = (r_func == FN_PUSH_FRONT);
    assign w_clear_last = (r_clr == SLOT_W'(TABLE_SLOTS - 1));
    // walk stops at the predecessor of the tail, or after a full table of steps
    assign w_walk_more  = (w_lk_rdata != w_t) && (r_steps < STEP_W'(TABLE_SLOTS));

    assign o_stat.in_valid   = i_req.valid;
    assign o_stat.out_free   = !r_out_valid || o_rsp.ready;
    assign o_stat.id_ok      = w_id_ok;
    assign o_stat.is_open    = w_open;
    assign o_stat.cnt_zero   = (w_c == '0);
    assign o_stat.cnt_one    = (w_c == CNT_W'(1));
    assign o_stat.free_empty = (r_free_head == '0);
    assign o_stat.walk_more  = w_walk_more;
    assign o_stat.clear_last = w_clear_last;
    assign o_stat.func       = r_func;

    assign i_req.ready     = i_cmd.in_ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.data_out  = r_out_dout;
    assign o_rsp.count_out = r_out_cnt;

    // link RAM port control
    always_comb begin
        w_lk_we    = 1'b0;
        w_lk_waddr = '0;
        w_lk_wdata = '0;
        w_lk_re    = 1'b0;
        w_lk_raddr = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = r_clr;
                w_lk_wdata = (r_clr == '0 || w_clear_last) ? '0 : r_clr + SLOT_W'(1);
            end
            OP_SCAN: begin
                w_lk_re = 1'b1;
                if (r_func == FN_OPEN || r_func == FN_PUSH_FRONT || r_func == FN_PUSH_BACK) begin
                    w_lk_raddr = r_free_head;
                end else begin
                    w_lk_raddr = w_h;
                end
            end
            OP_RELEASE, OP_PB_FREE: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = w_t;
                w_lk_wdata = r_free_head;
            end
            OP_OPEN: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = r_free_head;
            end
            OP_PUSH_TAKE: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = r_free_head;
                w_lk_wdata = w_front ? w_h : '0;
            end
            OP_PUSH_TAIL: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = w_t;
                w_lk_wdata = r_node;
            end
            OP_POP_FRONT: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = w_h;
                w_lk_wdata = r_free_head;
            end
            OP_WALK: begin
                w_lk_re    = w_walk_more;
                w_lk_raddr = w_lk_rdata;
            end
            OP_PB_CUT: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = r_p;
            end
            default: begin
                w_lk_we = 1'b0;
            end
        endcase
    end

    // slot RAM port control
    always_comb begin
        w_sl_we    = 1'b0;
        w_sl_waddr = '0;
        w_sl_re    = 1'b0;
        w_sl_raddr = '0;
        case (i_cmd.op)
            OP_SCAN: begin
                w_sl_re    = 1'b1;
                w_sl_raddr = (r_func == FN_POP_BACK) ? w_t : w_h;
            end
            OP_PUSH_HELD: begin
                w_sl_we    = 1'b1;
                w_sl_waddr = w_h;
            end
            OP_PUSH_TAKE: begin
                w_sl_we    = 1'b1;
                w_sl_waddr = r_free_head;
            end
            default: begin
                w_sl_we = 1'b0;
            end
        endcase
    end

    llqm_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_lk_we),
        .i_waddr (w_lk_waddr),
        .i_wdata (w_lk_wdata),
        .i_re    (w_lk_re),
        .i_raddr (w_lk_raddr),
        .o_rdata (w_lk_rdata)
    );

    llqm_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_sl_we),
        .i_waddr (w_sl_waddr),
        .i_wdata (DATA_W'(r_din)),
        .i_re    (w_sl_re),
        .i_raddr (w_sl_raddr),
        .o_rdata (w_sl_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_free_head <= SLOT_W'(1);
            r_open      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + SLOT_W'(1);
                OP_RELEASE: begin
                    r_free_head     <= w_h;
                    r_open[w_li]    <= 1'b0;
                    r_count[w_li]   <= '0;
                end
                OP_PUSH_HELD: r_count[w_li] <= CNT_W'(1);
                OP_OPEN: begin
                    r_free_head     <= w_lk_rdata;
                    r_open[w_li]    <= 1'b1;
                    r_count[w_li]   <= '0;
                end
                OP_PUSH_TAKE: begin
                    r_free_head     <= w_lk_rdata;
                    r_count[w_li]   <= w_c + CNT_W'(1);
                end
                OP_POP_ONE: r_count[w_li] <= '0;
                OP_POP_FRONT: begin
                    r_free_head     <= w_h;
                    r_count[w_li]   <= w_c - CNT_W'(1);
                end
                OP_PB_FREE: begin
                    r_free_head     <= w_t;
                    r_count[w_li]   <= w_c - CNT_W'(1);
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func <= i_req.func;
                r_id   <= i_req.list_id;
                r_din  <= i_req.data_in;
            end
            OP_SCAN: begin
                r_p          <= w_h;
                r_steps      <= '0;
                r_res_status <= i_cmd.status;
                r_res_dout   <= '0;
                r_res_cnt    <= w_id_ok ? w_c : '0;
            end
            OP_RELEASE: begin
                r_res_status <= STS_OK;
                r_res_dout   <= '0;
                r_res_cnt    <= '0;
            end
            OP_PUSH_HELD: begin
                r_res_status <= STS_OK;
                r_res_dout   <= '0;
                r_res_cnt    <= CNT_W'(1);
            end
            OP_OPEN: begin
                r_head[w_li] <= r_free_head;
                r_tail[w_li] <= r_free_head;
                r_res_status <= STS_OK;
                r_res_dout   <= '0;
                r_res_cnt    <= '0;
            end
            OP_PUSH_TAKE: begin
                if (w_front) r_head[w_li] <= r_free_head;
                r_node       <= r_free_head;
                r_res_status <= STS_OK;
                r_res_dout   <= '0;
                r_res_cnt    <= w_c + CNT_W'(1);
            end
            OP_PUSH_TAIL: r_tail[w_li] <= r_node;
            OP_POP_ONE: begin
                r_res_status <= STS_OK;
                r_res_dout   <= DOUT_W'(w_sl_rdata);
                r_res_cnt    <= '0;
            end
            OP_POP_FRONT: begin
                r_head[w_li] <= w_lk_rdata;
                r_res_status <= STS_OK;
                r_res_dout   <= DOUT_W'(w_sl_rdata);
                r_res_cnt    <= w_c - CNT_W'(1);
            end
            OP_WALK: begin
                if (w_walk_more) begin
                    r_p     <= w_lk_rdata;
                    r_steps <= r_steps + STEP_W'(1);
                end
            end
            OP_PB_CUT: r_res_dout <= DOUT_W'(w_sl_rdata);
            OP_PB_FREE: begin
                r_tail[w_li] <= r_p;
                r_res_status <= STS_OK;
                r_res_cnt    <= w_c - CNT_W'(1);
            end
            OP_EMIT: begin
                r_out_status <= r_res_status;
                r_out_dout   <= r_res_dout;
                r_out_cnt    <= COUNT_W'(r_res_cnt);
            end
            default: begin
                r_func <= r_func;
            end
        endcase
    end
endmodule

@@ src/linked_list_queue_manager_top.sv @@
// Accept in idle, decode, then: open takes a slot (open take); push with a new slot takes
// one (push take) and push back links it (push tail); a single-element pop and a pop front
// each have their own state; pop back of two or more walks the links, cuts and frees the
// tail. The output state registers the result when the output is free. One item at a time;
// next is accepted in idle. The link RAM ports and the pop-back walk set the pace. Reset:
// synchronous; then a pass over all 1024 link slots builds the free chain, input not ready.
`include "linked_list_queue_manager_top_assert.svh"

module linked_list_queue_manager_top import llqm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    llqm_req_if.sink    i_req,
    llqm_rsp_if.source  o_rsp
);
    t_cmd  w_cmd;
    t_stat w_stat;

    llqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    llqm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    `LLQM_ASSERT_NEXT(a_accept_then_decode, i_req.valid && i_req.ready,
        w_cmd.op == OP_SCAN || w_cmd.op == OP_RELEASE || w_cmd.op == OP_PUSH_HELD)
    `LLQM_ASSERT_IMPLY(a_emit_only_when_free, w_cmd.op == OP_EMIT, w_stat.out_free)
    `LLQM_ASSERT_IMPLY(a_cut_follows_walk, w_cmd.op == OP_PB_CUT, $past(w_cmd.op) == OP_WALK)
    `LLQM_ASSERT_NEXT(a_no_accept_in_clear, w_cmd.op == OP_CLEAR && !w_stat.clear_last,
        !i_req.ready)
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for linked_list_queue_manager_top: directed table, then
// random open/push/pop/release traffic checked against a shadow model of the slot pool.
// Depends on llqm_pkg, llqm_if and the top level RTL.
`timescale 1ns / 1ps

module tb_top;
    import llqm_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam int IDLE_PCT    = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 50;

    typedef enum int {MODE_MIX, MODE_FILL, MODE_EXHAUST} t_traffic_mode;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DOUT_W-1:0]   data_out;
        logic [COUNT_W-1:0]  count_out;
    } t_queue_result;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   id;
        logic [DIN_W-1:0]  din;
        bit                typed;
        t_queue_result     res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    llqm_req_if req_ch ();
    llqm_rsp_if rsp_ch ();

    linked_list_queue_manager_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow of the slot pool and list descriptors
    logic [SLOT_W-1:0] next_link  [TABLE_SLOTS];
    logic [DATA_W-1:0] slot_value [TABLE_SLOTS];
    logic [SLOT_W-1:0] free_ptr;
    logic [SLOT_W-1:0] list_head  [NUM_LISTS];
    logic [SLOT_W-1:0] list_tail  [NUM_LISTS];
    logic [CNT_W-1:0]  list_len   [NUM_LISTS];
    logic              list_open  [NUM_LISTS];

    t_queue_result pending_results[$];
    t_stim_row     directed_rows[$];
    int            error_count;
    int            items_sent;
    int            results_seen;

    function automatic t_queue_result apply_queue_op(logic [FUNC_W-1:0] fn,
                                                     logic [ID_W-1:0] id,
                                                     logic [DIN_W-1:0] din);
        t_queue_result     r;
        logic [SLOT_W-1:0] h, t, n, p;
        logic [CNT_W-1:0]  c;
        int                steps;
        r = '0;
        if (int'(id) >= NUM_LISTS) begin
            r.status = (fn <= FN_POP_BACK) ? STS_NOT_OPEN : STS_OK;
            return r;
        end
        if (fn == FN_OPEN) begin
            if (!list_open[id]) begin
                if (free_ptr == '0) begin
                    r.status = STS_EXHAUSTED;
                end else begin
                    n = free_ptr;
                    free_ptr = next_link[n];
                    next_link[n] = '0;
                    list_head[id] = n;
                    list_tail[id] = n;
                    list_len[id] = '0;
                    list_open[id] = 1'b1;
                end
            end
            r.count_out = list_len[id];
        end else if (fn > FN_POP_BACK) begin
            r.count_out = list_len[id];
        end else if (!list_open[id]) begin
            r.status = STS_NOT_OPEN;
            r.count_out = list_len[id];
        end else begin
            h = list_head[id];
            t = list_tail[id];
            c = list_len[id];
            case (fn)
                FN_RELEASE: begin
                    // whole chain, held slot included, goes to the free front
                    next_link[t] = free_ptr;
                    free_ptr = h;
                    list_open[id] = 1'b0;
                    c = '0;
                end
                FN_PUSH_FRONT, FN_PUSH_BACK: begin
                    if (c == '0) begin
                        slot_value[h] = din;
                        c = CNT_W'(1);
                    end else if (free_ptr == '0) begin
                        r.status = STS_EXHAUSTED;
                    end else begin
                        n = free_ptr;
                        free_ptr = next_link[n];
                        slot_value[n] = din;
                        if (fn == FN_PUSH_FRONT) begin
                            next_link[n] = h;
                            list_head[id] = n;
                        end else begin
                            next_link[n] = '0;
                            next_link[t] = n;
                            list_tail[id] = n;
                        end
                        c = c + CNT_W'(1);
                    end
                end
                default: begin
                    if (c == '0) begin
                        r.status = STS_EMPTY;
                    end else if (c == CNT_W'(1)) begin
                        r.data_out = slot_value[h];
                        c = '0;
                    end else if (fn == FN_POP_FRONT) begin
                        r.data_out = slot_value[h];
                        list_head[id] = next_link[h];
                        next_link[h] = free_ptr;
                        free_ptr = h;
                        c = c - CNT_W'(1);
                    end else begin
                        // find the slot before the tail
                        p = h;
                        steps = 0;
                        while (next_link[p] != t && steps < TABLE_SLOTS) begin
                            p = next_link[p];
                            steps++;
                        end
                        r.data_out = slot_value[t];
                        next_link[p] = '0;
                        next_link[t] = free_ptr;
                        free_ptr = t;
                        list_tail[id] = p;
                        c = c - CNT_W'(1);
                    end
                end
            endcase
            list_len[id] = c;
            r.count_out = c;
        end
        return r;
    endfunction

    function automatic t_stim_row typed_row(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                            logic [DIN_W-1:0] din, logic [STATUS_W-1:0] st,
                                            logic [DOUT_W-1:0] dout, logic [COUNT_W-1:0] cnt);
        t_stim_row row;
        row.fn = fn;
        row.id = id;
        row.din = din;
        row.typed = 1'b1;
        row.res.status = st;
        row.res.data_out = dout;
        row.res.count_out = cnt;
        return row;
    endfunction

    function automatic t_stim_row model_row(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                            logic [DIN_W-1:0] din);
        t_stim_row row;
        row.fn = fn;
        row.id = id;
        row.din = din;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic offer_item(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                              input logic [DIN_W-1:0] din, input bit typed,
                              input t_queue_result typed_res);
        t_queue_result predicted;
        bit            quiet;
        quiet = (items_sent >= 400 && items_sent < 600);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= fn;
        req_ch.list_id <= id;
        req_ch.data_in <= din;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_queue_op(fn, id, din);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic pick_item(input t_traffic_mode mode, output logic [FUNC_W-1:0] fn,
                             output logic [ID_W-1:0] id, output logic [DIN_W-1:0] din);
        int r;
        id = ID_W'($urandom_range(NUM_LISTS - 1));
        din = $urandom;
        r = $urandom_range(99);
        if (mode == MODE_MIX && r < 8) begin
            // noise: anything on any list
            fn = FUNC_W'($urandom_range(7));
        end else if (!list_open[id]) begin
            if (mode != MODE_MIX || r < 70)
                fn = FN_OPEN;
            else
                fn = FUNC_W'($urandom_range(1, 7));
        end else if (mode == MODE_FILL) begin
            if (r < 5)
                fn = FN_POP_FRONT;
            else
                fn = r[0] ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end else if (mode == MODE_EXHAUST) begin
            if (r < 15)
                fn = r[0] ? FN_POP_FRONT : FN_POP_BACK;
            else
                fn = r[0] ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end else begin
            r = $urandom_range(99);
            if (r < 25)      fn = FN_PUSH_FRONT;
            else if (r < 50) fn = FN_PUSH_BACK;
            else if (r < 70) fn = FN_POP_FRONT;
            else if (r < 82) fn = (list_len[id] > 300) ? FN_POP_FRONT : FN_POP_BACK;
            else if (r < 87) fn = FN_RELEASE;
            else if (r < 90) fn = FN_OPEN;
            else if (r < 95) fn = r[0] ? FN_SPARE_A : FN_SPARE_B;
            else             fn = FUNC_W'($urandom_range(7));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item status=%0d data=%h count=%0d", $time,
                         rsp_ch.status, rsp_ch.data_out, rsp_ch.count_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.data_out !== want.data_out) begin
                    $display("%0t: data_out expected %h actual %h", $time,
                             want.data_out, rsp_ch.data_out);
                    error_count++;
                end
                if (rsp_ch.count_out !== want.count_out) begin
                    $display("%0t: count_out expected %0d actual %0d", $time,
                             want.count_out, rsp_ch.count_out);
                    error_count++;
                end
            end
        end
    end

    // response side: random stalls, one long hold-off, a quiet stretch
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= 100) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (results_seen >= 400 && results_seen < 600) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus
    initial begin
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   id;
        logic [DIN_W-1:0]  din;

        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            next_link[i] = (i == 0 || i + 1 >= TABLE_SLOTS) ? '0 : SLOT_W'(i + 1);
            slot_value[i] = '0;
        end
        free_ptr = SLOT_W'(1);
        for (int i = 0; i < NUM_LISTS; i++) begin
            list_head[i] = '0;
            list_tail[i] = '0;
            list_len[i] = '0;
            list_open[i] = 1'b0;
        end

        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_OPEN;
        req_ch.list_id = '0;
        req_ch.data_in = '0;
        rsp_ch.ready = 1'b0;

        // closed lists, spare codes, empty pops, single element, held slot reuse
        directed_rows.push_back(typed_row(FN_POP_FRONT, 0, 32'h0, STS_NOT_OPEN, 0, 0));
        directed_rows.push_back(typed_row(FN_PUSH_BACK, 3, 32'hDEADBEEF, STS_NOT_OPEN, 0, 0));
        directed_rows.push_back(typed_row(FN_RELEASE, 5, 32'h0, STS_NOT_OPEN, 0, 0));
        directed_rows.push_back(typed_row(FN_POP_BACK, 9, 32'h0, STS_NOT_OPEN, 0, 0));
        directed_rows.push_back(typed_row(FN_SPARE_A, 0, 32'hFFFFFFFF, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_SPARE_B, 15, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_OPEN, 0, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_OPEN, 0, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_POP_FRONT, 0, 32'h0, STS_EMPTY, 0, 0));
        directed_rows.push_back(typed_row(FN_POP_BACK, 0, 32'h0, STS_EMPTY, 0, 0));
        directed_rows.push_back(typed_row(FN_PUSH_FRONT, 0, 32'hFFFFFFFF, STS_OK, 0, 1));
        directed_rows.push_back(typed_row(FN_POP_BACK, 0, 32'h0, STS_OK, 32'hFFFFFFFF, 0));
        directed_rows.push_back(typed_row(FN_PUSH_BACK, 0, 32'h0, STS_OK, 0, 1));
        directed_rows.push_back(typed_row(FN_PUSH_BACK, 0, 32'h12345678, STS_OK, 0, 2));
        directed_rows.push_back(typed_row(FN_PUSH_FRONT, 0, 32'h80000001, STS_OK, 0, 3));
        directed_rows.push_back(model_row(FN_POP_BACK, 0, 32'h0));
        directed_rows.push_back(model_row(FN_POP_FRONT, 0, 32'h0));
        directed_rows.push_back(model_row(FN_SPARE_B, 0, 32'h0));
        directed_rows.push_back(typed_row(FN_OPEN, 15, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_PUSH_FRONT, 15, 32'hA5A5A5A5, STS_OK, 0, 1));
        directed_rows.push_back(model_row(FN_PUSH_BACK, 15, 32'h5A5A5A5A));
        directed_rows.push_back(typed_row(FN_RELEASE, 15, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_POP_FRONT, 15, 32'h0, STS_NOT_OPEN, 0, 0));
        directed_rows.push_back(typed_row(FN_OPEN, 7, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_RELEASE, 7, 32'h0, STS_OK, 0, 0));
        directed_rows.push_back(typed_row(FN_RELEASE, 0, 32'h0, STS_OK, 0, 0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].fn, directed_rows[i].id, directed_rows[i].din,
                       directed_rows[i].typed, directed_rows[i].res);

        repeat (80) begin
            pick_item(MODE_MIX, fn, id, din);
            offer_item(fn, id, din, 1'b0, '0);
        end
        // fill the pool, then hammer it while exhausted
        while (free_ptr != '0) begin
            pick_item(MODE_FILL, fn, id, din);
            offer_item(fn, id, din, 1'b0, '0);
        end
        repeat (40) begin
            pick_item(MODE_EXHAUST, fn, id, din);
            offer_item(fn, id, din, 1'b0, '0);
        end
        repeat (60) begin
            pick_item(MODE_MIX, fn, id, din);
            offer_item(fn, id, din, 1'b0, '0);
        end
        for (int i = 0; i < NUM_LISTS; i++) begin
            if (list_open[i])
                offer_item(FN_RELEASE, ID_W'(i), $urandom, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
